FILE: rtl/roi_depth_centroid_backproject_top_defines.svh
`ifndef ROI_DEPTH_CENTROID_BACKPROJECT_TOP_DEFINES_SVH
`define ROI_DEPTH_CENTROID_BACKPROJECT_TOP_DEFINES_SVH

// cons must hold in every cycle in which ante holds
`define RDCB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdcb: check failed");

// expr must never hold
`define RDCB_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("rdcb: check failed");

`endif

FILE: rtl/rdcb_pkg.sv
package rdcb_pkg;

   localparam int COORD_BITS     = 12;
   localparam int DEPTH_LIMIT_MM = 20000;

   localparam int COL_W    = 12;
   localparam int DEPTH_W  = 16;
   localparam int BOUND_W  = 13;
   localparam int CENTER_W = 16;
   localparam int INVF_W   = 24;
   localparam int MAG_W    = 16;
   localparam int PROD1_W  = MAG_W + INVF_W;
   localparam int PROD2_W  = PROD1_W + DEPTH_W;
   localparam int FRAC_DROP = 20;
   localparam int TERM_W   = PROD2_W - FRAC_DROP + 1;
   localparam int ACC_XY_W = 64;
   localparam int ACC_Z_W  = 40;
   localparam int COUNT_W  = 25;
   localparam int XY_W     = 17;
   localparam int Z_W      = 15;

   localparam int NUM_W  = 64;
   localparam int DIV_W  = 33;
   localparam int STEP_W = $clog2(NUM_W);

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(64'd1 << 24);
   localparam logic [BOUND_W-1:0] COORD_MASK = BOUND_W'((64'd1 << COORD_BITS) - 64'd1);
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(DEPTH_LIMIT_MM);
   localparam logic [NUM_W-1:0]   XY_SAT = NUM_W'(65535);
   localparam logic [NUM_W-1:0]   Z_SAT  = NUM_W'(32767);
   localparam logic [PROD2_W:0]   ROUND_HALF = (PROD2_W + 1)'(64'd1 << (FRAC_DROP - 1));

   localparam logic [CSR_IDX_W-1:0] CSR_ROI_X_FIRST = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_X_END   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_Y_FIRST = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_Y_END   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_X = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_Y = 4'd7;

   typedef struct packed {
      logic [BOUND_W-1:0]  roi_x_first;
      logic [BOUND_W-1:0]  roi_x_end;
      logic [BOUND_W-1:0]  roi_y_first;
      logic [BOUND_W-1:0]  roi_y_end;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [INVF_W-1:0]   inv_focal_x;
      logic [INVF_W-1:0]   inv_focal_y;
   } cfg_type;

   typedef struct packed {
      logic               keep;
      logic               last;
      logic               neg_x;
      logic [MAG_W-1:0]   mag_x;
      logic               neg_y;
      logic [MAG_W-1:0]   mag_y;
      logic [DEPTH_W-1:0] depth;
   } pix_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic signed [ACC_XY_W-1:0] acc_x;
      logic signed [ACC_XY_W-1:0] acc_y;
      logic [ACC_Z_W-1:0]         acc_z;
      logic [COUNT_W-1:0]         count;
   } frame_sum_type;

endpackage

FILE: rtl/rdcb_if.sv
interface rdcb_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] col;
   logic [11:0] row;
   logic [15:0] depth_mm;
   logic        frame_last;
   modport source (output valid, col, row, depth_mm, frame_last, input ready);
   modport sink (input valid, col, row, depth_mm, frame_last, output ready);
endinterface

interface rdcb_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [16:0] point_x;
   logic signed [16:0] point_y;
   logic [14:0]        point_z;
   logic [24:0]        point_count;
   modport source (output valid, found, point_x, point_y, point_z, point_count, input ready);
   modport sink (input valid, found, point_x, point_y, point_z, point_count, output ready);
endinterface

interface rdcb_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/roi_depth_centroid_backproject_top.sv
// Depth centroid over a region of interest with pinhole back-projection. Pixels
// enter on req_port one per clock while the queue has room; the front classifies
// each pixel (nonzero depth below the limit, inside the half-open region) and puts
// it in a four-entry queue, and the back multiplies it out in a two-stage pipeline
// (offset times inverse focal length, then times depth) and adds it into the frame
// sums. A pixel carrying frame_last closes the frame: its sums go to a shared
// restoring divider that produces the x, y and z averages one quotient bit per
// cycle, a 64-bit quotient each. Pixels of the next frame keep flowing in
// meanwhile; only the next frame_last waits until the divider has handed its
// result to the output register. Write the csr_port registers between frames,
// with no pixel in flight.
module roi_depth_centroid_backproject_top (
   input  logic        clock,
   input  logic        reset,
   rdcb_req_if.sink    req_port,
   rdcb_rsp_if.source  rsp_port,
   rdcb_csr_if.sink    csr_port
);

   rdcb_pkg::cfg_type       cfg_ff;
   rdcb_pkg::fifo_stat_type fifo_stat;
   rdcb_pkg::pix_type       pix;
   rdcb_pkg::pix_type       head;
   rdcb_pkg::frame_sum_type sum;
   logic                    push;
   logic                    pop;
   logic                    start;
   logic                    div_idle;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            rdcb_pkg::CSR_ROI_X_FIRST: cfg_ff.roi_x_first <= csr_port.data[12:0];
            rdcb_pkg::CSR_ROI_X_END:   cfg_ff.roi_x_end   <= csr_port.data[12:0];
            rdcb_pkg::CSR_ROI_Y_FIRST: cfg_ff.roi_y_first <= csr_port.data[12:0];
            rdcb_pkg::CSR_ROI_Y_END:   cfg_ff.roi_y_end   <= csr_port.data[12:0];
            rdcb_pkg::CSR_CENTER_X:    cfg_ff.center_x    <= csr_port.data[15:0];
            rdcb_pkg::CSR_CENTER_Y:    cfg_ff.center_y    <= csr_port.data[15:0];
            rdcb_pkg::CSR_INV_FOCAL_X: cfg_ff.inv_focal_x <= csr_port.data;
            rdcb_pkg::CSR_INV_FOCAL_Y: cfg_ff.inv_focal_y <= csr_port.data;
            default: begin
            end
         endcase
      end
   end

   rdcb_front u_front (
      .cfg       (cfg_ff),
      .req_port  (req_port),
      .fifo_stat (fifo_stat),
      .push      (push),
      .pix       (pix)
   );

   rdcb_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (pix),
      .pop   (pop),
      .head  (head),
      .stat  (fifo_stat)
   );

   rdcb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fifo_stat (fifo_stat),
      .head      (head),
      .pop       (pop),
      .div_idle  (div_idle),
      .start     (start),
      .sum       (sum)
   );

   rdcb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .sum      (sum),
      .idle     (div_idle),
      .rsp_port (rsp_port)
   );

endmodule

FILE: rtl/rdcb_front.sv
module rdcb_front (
   input  rdcb_pkg::cfg_type       cfg,
   rdcb_req_if.sink                req_port,
   input  rdcb_pkg::fifo_stat_type fifo_stat,
   output logic                    push,
   output rdcb_pkg::pix_type       pix
);

   logic [rdcb_pkg::BOUND_W-1:0] u;
   logic [rdcb_pkg::BOUND_W-1:0] v;
   logic [rdcb_pkg::BOUND_W+3:0] pu;
   logic [rdcb_pkg::BOUND_W+3:0] pv;
   logic [rdcb_pkg::BOUND_W+3:0] cx;
   logic [rdcb_pkg::BOUND_W+3:0] cy;
   logic [rdcb_pkg::BOUND_W+3:0] dx;
   logic [rdcb_pkg::BOUND_W+3:0] dy;
   logic                         in_x;
   logic                         in_y;
   logic                         depth_ok;

   always_comb begin
      u  = rdcb_pkg::BOUND_W'(req_port.col) & rdcb_pkg::COORD_MASK;
      v  = rdcb_pkg::BOUND_W'(req_port.row) & rdcb_pkg::COORD_MASK;
      pu = {u, 4'b0000};
      pv = {v, 4'b0000};
      cx = (rdcb_pkg::BOUND_W + 4)'(cfg.center_x);
      cy = (rdcb_pkg::BOUND_W + 4)'(cfg.center_y);
      in_x = (u >= cfg.roi_x_first) && (u < cfg.roi_x_end);
      in_y = (v >= cfg.roi_y_first) && (v < cfg.roi_y_end);
      depth_ok = (req_port.depth_mm != '0) && (req_port.depth_mm < rdcb_pkg::DEPTH_LIMIT);

      pix.neg_x = pu < cx;
      pix.neg_y = pv < cy;
      dx = pix.neg_x ? (cx - pu) : (pu - cx);
      dy = pix.neg_y ? (cy - pv) : (pv - cy);
      pix.mag_x = dx[rdcb_pkg::MAG_W-1:0];
      pix.mag_y = dy[rdcb_pkg::MAG_W-1:0];
      pix.keep  = depth_ok && in_x && in_y;
      pix.last  = req_port.frame_last;
      pix.depth = req_port.depth_mm;
   end

   assign req_port.ready = !fifo_stat.full;
   assign push = req_port.valid && !fifo_stat.full;

endmodule

FILE: rtl/rdcb_fifo.sv
`include "roi_depth_centroid_backproject_top_defines.svh"

module rdcb_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rdcb_pkg::pix_type       din,
   input  logic                    pop,
   output rdcb_pkg::pix_type       head,
   output rdcb_pkg::fifo_stat_type stat
);

   rdcb_pkg::pix_type                entry_ff [rdcb_pkg::FIFO_DEPTH];
   logic [rdcb_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff;
   logic [rdcb_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff;
   logic [rdcb_pkg::FIFO_PTR_W:0]    fill_ff;
   logic [rdcb_pkg::FIFO_PTR_W:0]    fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = fill_ff == (rdcb_pkg::FIFO_PTR_W + 1)'(rdcb_pkg::FIFO_DEPTH);
   assign stat.empty = fill_ff == '0;

   `RDCB_ASSERT_NEVER(a_no_push_full, clock, reset, push && stat.full)
   `RDCB_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && stat.empty)

endmodule

FILE: rtl/rdcb_back.sv
`include "roi_depth_centroid_backproject_top_defines.svh"

module rdcb_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rdcb_pkg::cfg_type       cfg,
   input  rdcb_pkg::fifo_stat_type fifo_stat,
   input  rdcb_pkg::pix_type       head,
   output logic                    pop,
   input  logic                    div_idle,
   output logic                    start,
   output rdcb_pkg::frame_sum_type sum
);

   typedef struct packed {
      logic                          keep;
      logic                          last;
      logic                          neg_x;
      logic                          neg_y;
      logic [rdcb_pkg::DEPTH_W-1:0]  depth;
      logic [rdcb_pkg::PROD1_W-1:0]  prod_x;
      logic [rdcb_pkg::PROD1_W-1:0]  prod_y;
   } mul1_type;

   typedef struct packed {
      logic                          keep;
      logic                          last;
      logic                          neg_x;
      logic                          neg_y;
      logic [rdcb_pkg::DEPTH_W-1:0]  depth;
      logic [rdcb_pkg::PROD2_W-1:0]  prod_x;
      logic [rdcb_pkg::PROD2_W-1:0]  prod_y;
   } mul2_type;

   logic      s1_valid_ff;
   mul1_type  s1_ff;
   logic      s2_valid_ff;
   mul2_type  s2_ff;

   logic signed [rdcb_pkg::ACC_XY_W-1:0] acc_x_ff;
   logic signed [rdcb_pkg::ACC_XY_W-1:0] acc_y_ff;
   logic [rdcb_pkg::ACC_Z_W-1:0]         acc_z_ff;
   logic [rdcb_pkg::COUNT_W-1:0]         count_ff;
   logic                                 close_ff;

   logic [rdcb_pkg::PROD2_W:0]           round_x;
   logic [rdcb_pkg::PROD2_W:0]           round_y;
   logic [rdcb_pkg::TERM_W-1:0]          term_x;
   logic [rdcb_pkg::TERM_W-1:0]          term_y;
   logic signed [rdcb_pkg::ACC_XY_W-1:0] add_x;
   logic signed [rdcb_pkg::ACC_XY_W-1:0] add_y;
   logic                                 keep_eff;
   logic                                 last_in_flight;
   rdcb_pkg::frame_sum_type              sum_in;

   assign last_in_flight = (s1_valid_ff && s1_ff.last) || (s2_valid_ff && s2_ff.last)
                           || close_ff;
   assign pop = !fifo_stat.empty && (!head.last || (div_idle && !last_in_flight));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff.keep   <= head.keep;
      s1_ff.last   <= head.last;
      s1_ff.neg_x  <= head.neg_x;
      s1_ff.neg_y  <= head.neg_y;
      s1_ff.depth  <= head.depth;
      s1_ff.prod_x <= rdcb_pkg::PROD1_W'(head.mag_x) * rdcb_pkg::PROD1_W'(cfg.inv_focal_x);
      s1_ff.prod_y <= rdcb_pkg::PROD1_W'(head.mag_y) * rdcb_pkg::PROD1_W'(cfg.inv_focal_y);
      s2_ff.keep   <= s1_ff.keep;
      s2_ff.last   <= s1_ff.last;
      s2_ff.neg_x  <= s1_ff.neg_x;
      s2_ff.neg_y  <= s1_ff.neg_y;
      s2_ff.depth  <= s1_ff.depth;
      s2_ff.prod_x <= rdcb_pkg::PROD2_W'(s1_ff.prod_x) * rdcb_pkg::PROD2_W'(s1_ff.depth);
      s2_ff.prod_y <= rdcb_pkg::PROD2_W'(s1_ff.prod_y) * rdcb_pkg::PROD2_W'(s1_ff.depth);
   end

   always_comb begin
      round_x = (rdcb_pkg::PROD2_W + 1)'(s2_ff.prod_x) + rdcb_pkg::ROUND_HALF;
      round_y = (rdcb_pkg::PROD2_W + 1)'(s2_ff.prod_y) + rdcb_pkg::ROUND_HALF;
      term_x  = round_x[rdcb_pkg::PROD2_W:rdcb_pkg::FRAC_DROP];
      term_y  = round_y[rdcb_pkg::PROD2_W:rdcb_pkg::FRAC_DROP];
      add_x   = s2_ff.neg_x ? -$signed(rdcb_pkg::ACC_XY_W'(term_x))
                            : $signed(rdcb_pkg::ACC_XY_W'(term_x));
      add_y   = s2_ff.neg_y ? -$signed(rdcb_pkg::ACC_XY_W'(term_y))
                            : $signed(rdcb_pkg::ACC_XY_W'(term_y));
      sum_in.acc_x = close_ff ? '0 : acc_x_ff;
      sum_in.acc_y = close_ff ? '0 : acc_y_ff;
      sum_in.acc_z = close_ff ? '0 : acc_z_ff;
      sum_in.count = close_ff ? '0 : count_ff;
      keep_eff = s2_valid_ff && s2_ff.keep && (sum_in.count < rdcb_pkg::COUNT_MAX);
      if (keep_eff) begin
         sum_in.acc_x = sum_in.acc_x + add_x;
         sum_in.acc_y = sum_in.acc_y + add_y;
         sum_in.acc_z = sum_in.acc_z + rdcb_pkg::ACC_Z_W'(s2_ff.depth);
         sum_in.count = sum_in.count + 1'b1;
      end
   end

   assign start     = close_ff;
   assign sum.acc_x = acc_x_ff;
   assign sum.acc_y = acc_y_ff;
   assign sum.acc_z = acc_z_ff;
   assign sum.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_z_ff <= '0;
         count_ff <= '0;
         close_ff <= 1'b0;
      end else begin
         acc_x_ff <= sum_in.acc_x;
         acc_y_ff <= sum_in.acc_y;
         acc_z_ff <= sum_in.acc_z;
         count_ff <= sum_in.count;
         close_ff <= s2_valid_ff && s2_ff.last;
      end
   end

   `RDCB_ASSERT_NEVER(a_one_last_in_pipe, clock, reset,
      s1_valid_ff && s1_ff.last && s2_valid_ff && s2_ff.last)

endmodule

FILE: rtl/rdcb_div.sv
`include "roi_depth_centroid_backproject_top_defines.svh"

module rdcb_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  rdcb_pkg::frame_sum_type sum,
   output logic                    idle,
   rdcb_rsp_if.source              rsp_port
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      PH_X = 3'b001,
      PH_Y = 3'b010,
      PH_Z = 3'b100
   } phase_type;

   state_type                        state_ff;
   phase_type                        phase_ff;
   logic [rdcb_pkg::STEP_W-1:0]      step_ff;
   logic [rdcb_pkg::NUM_W-1:0]       num_ff;
   logic [rdcb_pkg::DIV_W-1:0]       rem_ff;
   logic [rdcb_pkg::DIV_W-1:0]       div_ff;
   logic                             neg_x_ff;
   logic                             neg_y_ff;
   logic [rdcb_pkg::NUM_W-1:0]       mag_y_ff;
   logic [rdcb_pkg::ACC_Z_W-1:0]     acc_z_ff;
   logic [rdcb_pkg::COUNT_W-1:0]     count_ff;
   logic                             found_ff;
   logic signed [rdcb_pkg::XY_W-1:0] res_x_ff;
   logic signed [rdcb_pkg::XY_W-1:0] res_y_ff;
   logic [rdcb_pkg::Z_W-1:0]         res_z_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_found_ff;
   logic signed [rdcb_pkg::XY_W-1:0] rsp_x_ff;
   logic signed [rdcb_pkg::XY_W-1:0] rsp_y_ff;
   logic [rdcb_pkg::Z_W-1:0]         rsp_z_ff;
   logic [rdcb_pkg::COUNT_W-1:0]     rsp_count_ff;

   logic [rdcb_pkg::DIV_W:0]         trial;
   logic                             ge;
   logic [rdcb_pkg::DIV_W-1:0]       rem_in;
   logic [rdcb_pkg::NUM_W-1:0]       num_in;
   logic [rdcb_pkg::NUM_W-1:0]       mag_x;
   logic [rdcb_pkg::NUM_W-1:0]       mag_y;
   logic                             last_step;
   logic                             out_free;

   function automatic logic signed [rdcb_pkg::XY_W-1:0] sat_xy(
      input logic [rdcb_pkg::NUM_W-1:0] q,
      input logic                       neg
   );
      logic signed [rdcb_pkg::XY_W-1:0] m;
      m = (q > rdcb_pkg::XY_SAT) ? rdcb_pkg::XY_W'(rdcb_pkg::XY_SAT) : rdcb_pkg::XY_W'(q);
      return neg ? -m : m;
   endfunction

   function automatic logic [rdcb_pkg::Z_W-1:0] sat_z(input logic [rdcb_pkg::NUM_W-1:0] q);
      return (q > rdcb_pkg::Z_SAT) ? rdcb_pkg::Z_W'(rdcb_pkg::Z_SAT) : rdcb_pkg::Z_W'(q);
   endfunction

   always_comb begin
      trial  = {rem_ff, num_ff[rdcb_pkg::NUM_W-1]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? rdcb_pkg::DIV_W'(trial - {1'b0, div_ff}) : trial[rdcb_pkg::DIV_W-1:0];
      num_in = {num_ff[rdcb_pkg::NUM_W-2:0], ge};
      last_step = step_ff == {rdcb_pkg::STEP_W{1'b1}};
      mag_x = sum.acc_x[rdcb_pkg::ACC_XY_W-1] ? (~sum.acc_x + 1'b1) : sum.acc_x;
      mag_y = sum.acc_y[rdcb_pkg::ACC_XY_W-1] ? (~sum.acc_y + 1'b1) : sum.acc_y;
      out_free = !rsp_valid_ff || rsp_port.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= (sum.count == '0) ? ST_HOLD : ST_RUN;
               end
            end
            ST_RUN: begin
               if (last_step && phase_ff == PH_Z) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_x_ff <= sum.acc_x[rdcb_pkg::ACC_XY_W-1];
               neg_y_ff <= sum.acc_y[rdcb_pkg::ACC_XY_W-1];
               mag_y_ff <= mag_y;
               acc_z_ff <= sum.acc_z;
               count_ff <= sum.count;
               num_ff   <= mag_x + rdcb_pkg::NUM_W'({sum.count, 7'b0});
               rem_ff   <= '0;
               div_ff   <= rdcb_pkg::DIV_W'({sum.count, 8'b0});
               step_ff  <= '0;
               phase_ff <= PH_X;
               found_ff <= 1'b0;
               res_x_ff <= '0;
               res_y_ff <= '0;
               res_z_ff <= '0;
            end
         end
         ST_RUN: begin
            step_ff <= step_ff + 1'b1;
            num_ff  <= num_in;
            rem_ff  <= rem_in;
            if (last_step) begin
               rem_ff <= '0;
               unique case (phase_ff)
                  PH_X: begin
                     res_x_ff <= sat_xy(num_in, neg_x_ff);
                     num_ff   <= mag_y_ff + rdcb_pkg::NUM_W'({count_ff, 7'b0});
                     phase_ff <= PH_Y;
                  end
                  PH_Y: begin
                     res_y_ff <= sat_xy(num_in, neg_y_ff);
                     num_ff   <= rdcb_pkg::NUM_W'(acc_z_ff)
                                 + rdcb_pkg::NUM_W'(count_ff[rdcb_pkg::COUNT_W-1:1]);
                     div_ff   <= rdcb_pkg::DIV_W'(count_ff);
                     phase_ff <= PH_Z;
                  end
                  PH_Z: begin
                     res_z_ff <= sat_z(num_in);
                     found_ff <= 1'b1;
                  end
                  default: phase_ff <= PH_X;
               endcase
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_found_ff <= found_ff;
               rsp_x_ff     <= res_x_ff;
               rsp_y_ff     <= res_y_ff;
               rsp_z_ff     <= res_z_ff;
               rsp_count_ff <= count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_HOLD && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign idle                 = state_ff == ST_IDLE;
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.found       = rsp_found_ff;
   assign rsp_port.point_x     = rsp_x_ff;
   assign rsp_port.point_y     = rsp_y_ff;
   assign rsp_port.point_z     = rsp_z_ff;
   assign rsp_port.point_count = rsp_count_ff;

   `RDCB_ASSERT_IMPL(a_start_when_idle, clock, reset, start, state_ff == ST_IDLE)
   `RDCB_ASSERT_IMPL(a_not_found_empty, clock, reset,
      rsp_valid_ff && !rsp_found_ff, rsp_count_ff == '0)

endmodule
